/* rtl/rle_pkg.sv */
// shared types, constants and functions of the led effect generator
package rle_pkg;

    localparam int MAX_COLORS = 8;
    localparam int TICK_MAX   = 1024;

    // mode codes
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_STEADY = 3'd1;
    localparam logic [2:0] MODE_PULSE  = 3'd2;
    localparam logic [2:0] MODE_FADEIN = 3'd3;
    localparam logic [2:0] MODE_FADEOUT = 3'd4;
    localparam logic [2:0] MODE_XFADE  = 3'd5;

    // register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_SPEED  = 3'd1;
    localparam logic [2:0] REG_POWER  = 3'd2;
    localparam logic [2:0] REG_COUNT  = 3'd3;
    localparam logic [2:0] REG_PAL_A  = 3'd4;
    localparam logic [2:0] REG_PAL_B  = 3'd5;
    localparam logic [2:0] REG_PAL_C  = 3'd6;
    localparam logic [2:0] REG_PAL_D  = 3'd7;

    // final scaling divides by 100 * 2^shift: shift first, then by 100
    localparam logic [4:0]  SH_STEADY   = 5'd0;
    localparam logic [4:0]  SH_XFADE    = 5'd5;
    localparam logic [4:0]  SH_EASE     = 5'd15;
    // ceil(2^27 / 100), exact floor division for dividends below 2^20
    localparam logic [20:0] RECIP_100   = 21'd1342178;
    localparam int          RECIP_SHIFT = 27;

    typedef struct packed {
        logic [2:0]   mode;
        logic [12:0]  dur;
        logic [2:0]   len;
        logic [6:0]   power;
        logic [3:0]   count;
        logic [191:0] pal;
    } cfg_t;

    typedef struct packed {
        logic [9:0] tick;
        logic [2:0] cur;
        logic [2:0] nxt;
    } job_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > v)
                b = b >> 2;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // fractional powers of two in q.30, one entry per 8-bit fraction
    function automatic logic [256*31-1:0] build_expo_tab();
        logic [63:0] roots [8];
        logic [63:0] m;
        logic [256*31-1:0] tab;
        roots[0] = isqrt64(64'd1 << 61);
        for (int j = 1; j < 8; j++)
            roots[j] = isqrt64(roots[j-1] << 30);
        tab = '0;
        for (int f = 0; f < 256; f++)
        begin
            m = 64'd1 << 30;
            for (int b = 0; b < 8; b++)
            begin
                if (((f >> b) & 1) == 1)
                    m = (m * roots[7-b]) >> 30;
            end
            tab[f*31 +: 31] = m[30:0];
        end
        return tab;
    endfunction

    localparam logic [256*31-1:0] EXPO_TAB = build_expo_tab();

    function automatic logic [2:0] idx_mod(input logic [2:0] i, input logic [3:0] n);
        logic [3:0] v;
        v = {1'b0, i};
        for (int k = 0; k < 7; k++)
        begin
            if (v >= n)
                v = v - n;
        end
        return v[2:0];
    endfunction

    function automatic logic [2:0] idx_next(input logic [2:0] cur, input logic [3:0] n);
        logic [3:0] c1;
        c1 = {1'b0, cur} + 4'd1;
        return (c1 >= n) ? 3'd0 : c1[2:0];
    endfunction

    function automatic logic [23:0] color_of(input logic [191:0] pal, input logic [2:0] i);
        return pal[i*24 +: 24];
    endfunction

endpackage

/* rtl/rle_ifs.sv */
// channel interfaces of the led effect generator
interface rle_adv_if;
    logic       valid;
    logic       ready;
    logic [7:0] advance_ms;
    modport source (output valid, output advance_ms, input ready);
    modport sink (input valid, input advance_ms, output ready);
endinterface

interface rle_lvl_if;
    logic        valid;
    logic        ready;
    logic [12:0] red_level;
    logic [12:0] green_level;
    logic [12:0] blue_level;
    modport source (output valid, output red_level, output green_level, output blue_level,
                    input ready);
    modport sink (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

interface rle_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/rgb_led_effect_generator.sv */
// top level of the rgb led effect generator
// Each input word carries the milliseconds gone by since the last one. The
// front end adds them to the elapsed counter; past the colour period
// (72*(101-speed) ms) it emits nothing, steps the palette index and restarts,
// otherwise it divides the elapsed time bit-serially into a phase tick
// and takes no new word until that job is queued. Jobs wait in a two entry
// queue for the back end, which eases the tick, forms the three channel
// products and scales them by power with a shift and a reciprocal
// multiplication, one job at a time. A finished word sits in an output
// register while the next job proceeds. Configuration words are taken at
// any time and must only be written while the block is idle; writing
// speed, power or a new mode restarts the effect at colour zero.
module rgb_led_effect_generator
    import rle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rle_adv_if.sink      in_ch,
    rle_lvl_if.source    out_ch,
    rle_cfg_if.sink      cfg_ch
);

    logic [2:0]   mode_reg;
    logic [6:0]   speed_reg;
    logic [6:0]   power_reg;
    logic [3:0]   count_reg;
    logic [191:0] pal_reg;
    logic         restart;
    logic [6:0]   speed_eff;
    logic [12:0]  dur;
    cfg_t         cfg;
    logic         q_push, q_full, q_pop, q_valid;
    job_t         push_job, pop_job;

    // config port always takes a word
    assign cfg_ch.ready = 1'b1;

    // restart on speed, power or a changed mode
    always_comb
    begin
        restart = 1'b0;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_MODE:             restart = (cfg_ch.data[2:0] != mode_reg);
                REG_SPEED, REG_POWER: restart = 1'b1;
                default:              restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_STEADY;
            speed_reg <= 7'd0;
            power_reg <= 7'd100;
            count_reg <= 4'd1;
            pal_reg   <= {168'd0, 24'hFF0000};
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_MODE:  mode_reg  <= cfg_ch.data[2:0];
                REG_SPEED: speed_reg <= cfg_ch.data[6:0];
                REG_POWER: power_reg <= cfg_ch.data[6:0];
                REG_COUNT: count_reg <= cfg_ch.data[3:0];
                REG_PAL_A: pal_reg[47:0]    <= cfg_ch.data;
                REG_PAL_B: pal_reg[95:48]   <= cfg_ch.data;
                REG_PAL_C: pal_reg[143:96]  <= cfg_ch.data;
                REG_PAL_D: pal_reg[191:144] <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    // clamped settings; period is 7200*(101-speed)/100 = 72*(101-speed)
    assign speed_eff = (speed_reg > 7'd100) ? 7'd100 : speed_reg;
    assign dur       = 13'(7'd72 * (7'd101 - speed_eff));
    assign cfg.mode  = mode_reg;
    assign cfg.dur   = dur;
    assign cfg.len   = (dur[12:10] == 3'd0) ? 3'd1 : dur[12:10];
    assign cfg.power = (power_reg > 7'd100) ? 7'd100 : power_reg;
    assign cfg.count = (count_reg == 4'd0) ? 4'd1 :
                       (count_reg > 4'(MAX_COLORS)) ? 4'(MAX_COLORS) : count_reg;
    assign cfg.pal   = pal_reg;

    rle_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (in_ch),
        .cfg     (cfg),
        .restart (restart),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    rle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_job   (pop_job)
    );

    rle_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .lvl     (out_ch)
    );

endmodule

/* rtl/rle_front.sv */
// front end: elapsed time, colour index and phase tick division
module rle_front
    import rle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rle_adv_if.sink      adv,
    input  cfg_t         cfg,
    input  logic         restart,
    input  logic         q_full,
    output logic         q_push,
    output job_t         q_job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [13:0] elapsed_reg, elapsed_next;
    logic [2:0]  idx_reg, idx_next_v;
    logic [2:0]  cur_reg, cur_next;
    logic [2:0]  nxt_reg, nxt_next;
    logic [3:0]  bit_reg, bit_next;
    logic [2:0]  rem_reg, rem_next;
    logic [13:0] quo_reg, quo_next;

    logic [2:0]  cur_now;
    logic [13:0] el_sum;
    logic [3:0]  trial;
    logic [9:0]  tick;

    // no word taken in the cycle a restart clears the state
    assign adv.ready = (state_reg == F_IDLE) && !restart;
    assign cur_now   = idx_mod(idx_reg, cfg.count);
    assign el_sum    = elapsed_reg + {6'd0, adv.advance_ms};
    assign trial     = {rem_reg, elapsed_reg[bit_reg]};

    always_comb
    begin
        if (quo_reg < 14'd10)
            tick = 10'd10;
        else if (quo_reg > 14'd1014)
            tick = 10'd1014;
        else
            tick = quo_reg[9:0];
    end

    assign q_push     = (state_reg == F_PUSH) && !q_full;
    assign q_job.tick = tick;
    assign q_job.cur  = cur_reg;
    assign q_job.nxt  = nxt_reg;

    always_comb
    begin
        state_next   = state_reg;
        elapsed_next = elapsed_reg;
        idx_next_v   = idx_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        bit_next     = bit_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (restart)
                begin
                    elapsed_next = 14'd0;
                    idx_next_v   = 3'd0;
                end
                else if (adv.valid)
                begin
                    if (el_sum > {1'b0, cfg.dur})
                    begin
                        // period over: next colour, nothing emitted
                        idx_next_v   = idx_next(cur_now, cfg.count);
                        elapsed_next = 14'd0;
                    end
                    else
                    begin
                        elapsed_next = el_sum;
                        cur_next     = cur_now;
                        nxt_next     = idx_next(cur_now, cfg.count);
                        bit_next     = 4'd13;
                        rem_next     = 3'd0;
                        quo_next     = 14'd0;
                        state_next   = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                if (trial >= {1'b0, cfg.len})
                begin
                    rem_next = 3'(trial - {1'b0, cfg.len});
                    quo_next = {quo_reg[12:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[2:0];
                    quo_next = {quo_reg[12:0], 1'b0};
                end
                if (bit_reg == 4'd0)
                    state_next = F_PUSH;
                else
                    bit_next = bit_reg - 4'd1;
            end
            F_PUSH:
            begin
                if (!q_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            elapsed_reg <= 14'd0;
            idx_reg     <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            idx_reg     <= idx_next_v;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        nxt_reg <= nxt_next;
        bit_reg <= bit_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

/* rtl/rle_queue.sv */
// two entry job queue between front and back
module rle_queue
    import rle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t pop_job
);

    job_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_job   = slot_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_job;
    end

endmodule

/* rtl/rle_back.sv */
// back end: easing, channel products and scaling division
module rle_back
    import rle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       q_pop,
    rle_lvl_if.source  lvl
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EASE  = 6'b000010,
        S_PROD  = 6'b000100,
        S_SCALE = 6'b001000,
        S_DIV   = 6'b010000,
        S_PUT   = 6'b100000
    } bstate_t;

    bstate_t     state_reg;
    job_t        job_reg;
    logic [20:0] e_reg;
    logic [23:0] col_reg, nxt_reg;
    logic [28:0] a_reg [3];
    logic [35:0] prod_reg [3];
    logic [12:0] q_reg [3];
    logic [4:0]  sh_reg;
    logic        ov_reg;
    logic [12:0] red_reg, green_reg, blue_reg;

    logic [10:0] u;
    logic [9:0]  t8;
    logic [9:0]  d;
    logic [19:0] sq;
    logic [20:0] quad;
    logic [11:0] k;
    logic [30:0] m;
    logic [20:0] expo;
    logic [20:0] e;
    logic [19:0] y_sh [3];
    logic [40:0] rq [3];
    logic        put;

    // easing curves
    always_comb
    begin
        if (job_reg.tick < 10'd81)
            t8 = 10'd81;
        else if (job_reg.tick > 10'd943)
            t8 = 10'd943;
        else
            t8 = job_reg.tick;
        case (cfg.mode)
            MODE_FADEIN:  u = {1'b0, job_reg.tick};
            MODE_FADEOUT: u = 11'(TICK_MAX) - {1'b0, t8};
            default:      u = 11'(TICK_MAX) - {1'b0, job_reg.tick};
        endcase
        d    = (u < 11'd512) ? u[9:0] : 10'(11'(TICK_MAX) - u);
        sq   = d * d;
        quad = (u < 11'd512) ? {sq, 1'b0} : 21'(22'd1048576 - {1'b0, sq, 1'b0});
        k    = 12'(5 * job_reg.tick);
        m    = EXPO_TAB[k[7:0]*31 +: 31];
        expo = 21'(m >> (5'd21 - {1'b0, k[11:8]}));
        if (cfg.mode == MODE_PULSE && job_reg.tick < 10'd512)
            e = expo;
        else
            e = quad;
    end

    // divide by 100 * 2^shift: the shifted value stays below 2^20
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            y_sh[ch] = 20'(prod_reg[ch] >> sh_reg);
            rq[ch]   = y_sh[ch] * RECIP_100;
        end
    end

    assign put       = (state_reg == S_PUT) && (!ov_reg || lvl.ready);
    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign lvl.valid = ov_reg;
    assign lvl.red_level   = red_reg;
    assign lvl.green_level = green_reg;
    assign lvl.blue_level  = blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (q_valid) state_reg <= S_EASE;
                S_EASE:  state_reg <= S_PROD;
                S_PROD:  state_reg <= S_SCALE;
                S_SCALE: state_reg <= S_DIV;
                S_DIV:   state_reg <= S_PUT;
                S_PUT:   if (put) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            if (put)
                ov_reg <= 1'b1;
            else if (lvl.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
        if (state_reg == S_EASE)
        begin
            e_reg   <= e;
            col_reg <= color_of(cfg.pal, job_reg.cur);
            nxt_reg <= color_of(cfg.pal, job_reg.nxt);
        end
        if (state_reg == S_PROD)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                case (cfg.mode)
                    MODE_STEADY:
                        a_reg[ch] <= 29'(col_reg[16-8*ch +: 8]);
                    MODE_PULSE, MODE_FADEIN, MODE_FADEOUT:
                        a_reg[ch] <= col_reg[16-8*ch +: 8] * e_reg;
                    MODE_XFADE:
                        a_reg[ch] <= 29'(col_reg[16-8*ch +: 8]
                                         * (11'(TICK_MAX) - {1'b0, job_reg.tick})
                                         + nxt_reg[16-8*ch +: 8] * job_reg.tick);
                    default:
                        a_reg[ch] <= 29'd0;
                endcase
            end
            case (cfg.mode)
                MODE_STEADY: sh_reg <= SH_STEADY;
                MODE_XFADE:  sh_reg <= SH_XFADE;
                default:     sh_reg <= SH_EASE;
            endcase
        end
        if (state_reg == S_SCALE)
        begin
            for (int ch = 0; ch < 3; ch++)
                prod_reg[ch] <= a_reg[ch] * cfg.power;
        end
        if (state_reg == S_DIV)
        begin
            // quotient by reciprocal multiplication in each lane
            for (int ch = 0; ch < 3; ch++)
                q_reg[ch] <= rq[ch][RECIP_SHIFT+12:RECIP_SHIFT];
        end
        if (put)
        begin
            if (cfg.mode == MODE_STEADY)
            begin
                red_reg   <= {q_reg[0][7:0], 5'd0};
                green_reg <= {q_reg[1][7:0], 5'd0};
                blue_reg  <= {q_reg[2][7:0], 5'd0};
            end
            else
            begin
                red_reg   <= q_reg[0];
                green_reg <= q_reg[1];
                blue_reg  <= q_reg[2];
            end
        end
    end

endmodule

/* verif/tb_rgb_led_effect_generator.sv */
// testbench of the rgb led effect generator: directed table, random phases, self-checking
`timescale 1ns / 1ps

module tb_rgb_led_effect_generator;
    import rle_pkg::*;

    typedef struct packed {
        logic [12:0] red;
        logic [12:0] green;
        logic [12:0] blue;
    } level_t;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {ROW_CFG, ROW_WORD, ROW_WORD_CHK} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  index;
        logic [47:0] data;
        logic [7:0]  adv;
        level_t      lvl;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rle_adv_if in_ch ();
    rle_lvl_if out_ch ();
    rle_cfg_if cfg_ch ();

    rgb_led_effect_generator dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    always #1 clk = ~clk;

    // local copy of the block's registers and effect state
    logic [2:0]  shadow_mode;
    logic [6:0]  shadow_speed;
    logic [6:0]  shadow_power;
    logic [3:0]  shadow_count;
    logic [47:0] shadow_pal [4];
    logic [13:0] shadow_elapsed;
    logic [2:0]  shadow_index;
    longint unsigned root_q30 [8];

    level_t levels_due [$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     long_hold_req = 1'b0;

    function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned b;
        v   = v_in;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned quad_ease(input int unsigned u);
        if (u < 512)
            return 2 * u * u;
        return (64'd1 << 20) - 2 * (1024 - u) * (1024 - u);
    endfunction

    // 2^(5t/256 - 11) in q.20, fraction built from chained square roots
    function automatic longint unsigned expo_ease(input int unsigned t);
        int unsigned k;
        longint unsigned m;
        k = 5 * t;
        m = 64'd1 << 30;
        for (int b = 0; b < 8; b++)
        begin
            if (k[b])
                m = (m * root_q30[7-b]) >> 30;
        end
        return (m << ((k >> 8) + 9)) >> 30;
    endfunction

    function automatic logic [23:0] palette_color(input int unsigned i);
        logic [47:0] pair;
        pair = shadow_pal[(i >> 1) & 3];
        return i[0] ? pair[47:24] : pair[23:0];
    endfunction

    function automatic void reset_effect();
        shadow_elapsed = '0;
        shadow_index   = '0;
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [47:0] val);
        case (idx)
            REG_MODE:
            begin
                if (val[2:0] != shadow_mode)
                begin
                    shadow_mode = val[2:0];
                    reset_effect();
                end
            end
            REG_SPEED:
            begin
                shadow_speed = val[6:0];
                reset_effect();
            end
            REG_POWER:
            begin
                shadow_power = val[6:0];
                reset_effect();
            end
            REG_COUNT: shadow_count = val[3:0];
            default:   shadow_pal[idx - REG_PAL_A] = val;
        endcase
    endfunction

    // advance the effect by one word; returns 0 when the period wraps
    function automatic bit effect_step(input logic [7:0] adv, output level_t lvl);
        int unsigned spd, pw, cnt, dur, cur, len, tick, t8;
        longint unsigned c, n, e, v;
        logic [23:0] col, nxt;
        logic [12:0] ch [3];
        spd = (shadow_speed > 100) ? 100 : shadow_speed;
        pw  = (shadow_power > 100) ? 100 : shadow_power;
        cnt = (shadow_count < 1) ? 1 : (shadow_count > MAX_COLORS) ? MAX_COLORS : shadow_count;
        dur = 7200 * (101 - spd) / 100;
        cur = shadow_index % cnt;
        shadow_elapsed = shadow_elapsed + adv;
        lvl = '0;
        if (shadow_elapsed > dur)
        begin
            shadow_index   = (cur + 1) % cnt;
            shadow_elapsed = '0;
            return 1'b0;
        end
        len  = (dur / 1024 < 1) ? 1 : dur / 1024;
        tick = shadow_elapsed / len;
        if (tick < 10)
            tick = 10;
        if (tick > 1014)
            tick = 1014;
        col = palette_color(cur);
        nxt = palette_color((cur + 1) % cnt);
        for (int i = 0; i < 3; i++)
        begin
            c = col[16 - 8*i +: 8];
            n = nxt[16 - 8*i +: 8];
            case (shadow_mode)
                MODE_STEADY: v = ((c * pw) / 100) << 5;
                MODE_PULSE:
                begin
                    e = (tick < 512) ? expo_ease(tick) : quad_ease(1024 - tick);
                    v = (c * e * pw) / (100 << 15);
                end
                MODE_FADEIN: v = (c * quad_ease(tick) * pw) / (100 << 15);
                MODE_FADEOUT:
                begin
                    t8 = (tick < 81) ? 81 : (tick > 943) ? 943 : tick;
                    v  = (c * quad_ease(1024 - t8) * pw) / (100 << 15);
                end
                MODE_XFADE: v = ((c * (1024 - tick) + n * tick) * pw) / 3200;
                default:    v = 0;
            endcase
            ch[i] = v[12:0];
        end
        lvl.red   = ch[0];
        lvl.green = ch[1];
        lvl.blue  = ch[2];
        return 1'b1;
    endfunction

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == 3000000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random back-pressure, compares every accepted word
    int hold_left = 0;
    always @(posedge clk)
    begin
        level_t got;
        level_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.red_level, out_ch.green_level, out_ch.blue_level};
            if (levels_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
            end
            else
            begin
                want = levels_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("level mismatch: want r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
        // long hold-off so the queue in front of the back end fills and input stalls
        if (long_hold_req && hold_left < 600)
        begin
            hold_left = 800;
            long_hold_req = 1'b0;
        end
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if ($urandom_range(99) < 70)
            out_ch.ready <= 1'b1;
        else
        begin
            hold_left = ($urandom_range(99) < 8) ? $urandom_range(60, 20) : $urandom_range(3, 1);
            out_ch.ready <= 1'b0;
        end
    end

    task automatic idle_gap();
        int gap;
        int r;
        r   = $urandom_range(99);
        gap = (r < 55) ? 0 : (r < 95) ? $urandom_range(3, 1) : $urandom_range(50, 10);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // offer one word; expectation is pushed at the edge it is taken
    task automatic send_word(input logic [7:0] adv, input bit typed, input level_t typed_lvl);
        level_t lvl;
        idle_gap();
        in_ch.valid      <= 1'b1;
        in_ch.advance_ms <= adv;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (effect_step(adv, lvl))
            levels_due.push_back(typed ? typed_lvl : lvl);
    endtask

    // register write, only once everything in flight has come out
    task automatic write_register(input logic [2:0] idx, input logic [47:0] val);
        in_ch.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        apply_register(idx, val);
    endtask

    row_t rows [$];
    level_t none = '0;

    function automatic void add_cfg(input logic [2:0] idx, input logic [47:0] val);
        rows.push_back('{ROW_CFG, idx, val, 8'd0, '0});
    endfunction

    function automatic void add_word(input logic [7:0] adv);
        rows.push_back('{ROW_WORD, 3'd0, 48'd0, adv, '0});
    endfunction

    function automatic void add_checked(input logic [7:0] adv, input level_t lvl);
        rows.push_back('{ROW_WORD_CHK, 3'd0, 48'd0, adv, lvl});
    endfunction

    initial
    begin
        logic [2:0] m;
        int spd;
        in_ch.valid      = 1'b0;
        in_ch.advance_ms = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        out_ch.ready     = 1'b0;

        root_q30[0] = sqrt_floor(64'd1 << 61);
        for (int j = 1; j < 8; j++)
            root_q30[j] = sqrt_floor(root_q30[j-1] << 30);
        shadow_mode  = MODE_STEADY;
        shadow_speed = 7'd0;
        shadow_power = 7'd100;
        shadow_count = 4'd1;
        shadow_pal   = '{48'hFF0000, 48'd0, 48'd0, 48'd0};
        reset_effect();

        // directed table: reset state, clamps, every mode, wrap of the period
        add_checked(8'd0, '{13'd8160, 13'd0, 13'd0});   // reset palette: full red
        add_word(8'd255);
        add_cfg(REG_POWER, 48'd0);
        add_checked(8'd7, none);                        // zero power gives black
        add_cfg(REG_POWER, 48'd127);                    // power above 100 clamps
        add_cfg(REG_MODE, {45'd0, MODE_OFF});
        add_checked(8'd1, none);
        add_cfg(REG_MODE, 48'd7);                       // undefined mode: black
        add_checked(8'd1, none);
        add_cfg(REG_PAL_A, 48'hFFFFFF_FFFFFF);
        add_cfg(REG_PAL_B, 48'h0000FF_00FF00);
        add_cfg(REG_COUNT, 48'd0);                      // count zero acts as one
        add_cfg(REG_MODE, {45'd0, MODE_PULSE});
        add_cfg(REG_SPEED, 48'd127);                    // shortest period, speed clamped
        add_word(8'd0);
        add_word(8'd30);
        add_word(8'd41);
        add_word(8'd200);                               // past the period: no word
        add_cfg(REG_COUNT, 48'd15);                     // count above max saturates
        add_cfg(REG_MODE, {45'd0, MODE_FADEIN});
        add_word(8'd36);
        add_cfg(REG_MODE, {45'd0, MODE_FADEOUT});
        add_word(8'd5);
        add_word(8'd66);
        add_cfg(REG_MODE, {45'd0, MODE_XFADE});
        add_word(8'd36);
        add_word(8'd255);
        add_word(8'd10);
        add_cfg(REG_MODE, {45'd0, MODE_XFADE});         // same mode: no restart
        add_word(8'd20);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_register(rows[i].index, rows[i].data);
            else
                send_word(rows[i].adv, rows[i].kind == ROW_WORD_CHK, rows[i].lvl);
        end

        // random phases: each rewrites every register, then a burst of words
        for (int ph = 0; ph < 8; ph++)
        begin
            m   = ph[2:0];
            spd = (ph == 0) ? 0 : (ph % 3 == 1) ? 100 : (ph == 5) ? 127 : $urandom_range(100, 80);
            write_register(REG_PAL_A, {$urandom, $urandom});
            write_register(REG_PAL_B, {$urandom, $urandom});
            write_register(REG_PAL_C, {$urandom, $urandom});
            write_register(REG_PAL_D, {$urandom, $urandom});
            write_register(REG_COUNT, $urandom_range(15));
            write_register(REG_POWER, (ph == 3) ? 0 : (ph % 2) ? 100 : $urandom_range(127));
            write_register(REG_SPEED, spd);
            write_register(REG_MODE, ($urandom_range(3) == 0) ? $urandom_range(7) : m);
            if (ph == 2)
                long_hold_req = 1'b1;
            for (int k = 0; k < 180; k++)
                send_word(($urandom_range(9) == 0) ? 8'd255 : $urandom_range(255), 1'b0, none);
        end

        in_ch.valid <= 1'b0;
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
